// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the tokenizer.
// No dependencies; the user includes this header by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that stays quiet while reset is high.
`define QTS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check that is also evaluated during reset.
`define QTS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/qts_pkg.sv =====
// Shared types and constants of the quoted token splitter.
// No dependencies; the top level and its checker use it by scoped names.
package qts_pkg;

   localparam int BUFFER_BYTES_DEFAULT = 65536;
   localparam int POS_BITS = 16;

   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       buffer_start;
      logic       buffer_last;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] token_offset;
      logic [15:0] token_length;
      logic        was_quoted;
      logic        ends_line;
      logic        unterminated;
   } rsp_payload_type;

endpackage

// ===== sv/quoted_token_splitter.sv =====
// Top level of the quoted token splitter: input register, token state, result register.
// Depends on qts_pkg for payload types and character codes.
//
// Usage:
//   req_*  : one text byte per beat (req_valid/req_stall, req_stall driven here),
//            with buffer_start on the first byte and buffer_last on the final one.
//   rsp_*  : one beat per finished token (offset, length, flags); rsp_stall from
//            the receiver holds the result register.
//   csr_*  : write of use_escape; csr_ready is always high, write only while idle.
// Path: an accepted byte is held in the input register; once the result register
//   is free, a byte that ends a token loads its result there, and the result
//   register drives rsp_valid and rsp_data.
// Throughput: one byte per cycle unless a byte that ends a token waits for the
//   result register; the token state updates as each byte leaves the input register.
// Stall: bytes that end no token keep flowing while a result waits; a byte that
//   ends a token waits in the input register, with req_stall high, until the
//   result register frees.
// Reset: clears position, token state, use_escape and both valid flags.
module quoted_token_splitter #(
   parameter int BUFFER_BYTES = qts_pkg::BUFFER_BYTES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  qts_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output qts_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_data
);

   localparam int PW = qts_pkg::POS_BITS;
   // Highest position the counter reaches: the buffer size minus one, at most 65535.
   localparam int CapInt = (BUFFER_BYTES - 1 > 65535) ? 65535 : BUFFER_BYTES - 1;
   localparam logic [PW-1:0] POS_CAP = PW'(CapInt);

   function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
      return (v >= POS_CAP) ? POS_CAP : v + 1'b1;
   endfunction

   // configuration
   logic use_escape_ff;

   // input register
   logic                     s1_valid_ff, s1_valid_in;
   qts_pkg::req_payload_type s1_data_ff;

   // token state
   logic [PW-1:0] pos_ff, pos_in;
   logic          in_token_ff, in_token_in;
   logic          in_quote_ff, in_quote_in;
   logic          dquote_ff, dquote_in;
   logic          esc_ff, esc_in;
   logic [PW-1:0] start_ff, start_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   qts_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   // per-byte evaluation
   logic          has_result;
   logic [PW:0]   res_end;
   logic [PW-1:0] res_start;
   logic          res_quoted, res_line, res_open;
   logic [PW:0]   res_len;
   logic          out_free, s1_advance;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_escape_ff <= 1'b0;
      end else if (csr_valid) begin
         use_escape_ff <= csr_data;
      end
   end

   // Evaluate the byte held in the input register against the token state.
   always_comb begin
      logic [7:0]    c;
      logic [7:0]    quote_char;
      logic [PW-1:0] idx;
      logic          tok, quo, dq, esc;
      logic [PW-1:0] st;

      c   = s1_data_ff.text_byte;
      // A new buffer clears position and token state before this byte.
      idx = s1_data_ff.buffer_start ? '0   : pos_ff;
      tok = s1_data_ff.buffer_start ? 1'b0 : in_token_ff;
      quo = s1_data_ff.buffer_start ? 1'b0 : in_quote_ff;
      dq  = s1_data_ff.buffer_start ? 1'b0 : dquote_ff;
      esc = s1_data_ff.buffer_start ? 1'b0 : esc_ff;
      st  = s1_data_ff.buffer_start ? '0   : start_ff;
      quote_char = dq ? qts_pkg::CHAR_DQUOTE : qts_pkg::CHAR_SQUOTE;

      in_token_in = tok;
      in_quote_in = quo;
      dquote_in   = dq;
      esc_in      = esc;
      start_in    = st;
      has_result  = 1'b0;
      res_end     = {1'b0, idx};
      res_start   = st;
      res_quoted  = 1'b0;
      res_line    = 1'b0;
      res_open    = 1'b0;

      if (quo) begin
         if (esc) begin
            esc_in = 1'b0;
         end else if (use_escape_ff && c == qts_pkg::CHAR_BSLASH) begin
            esc_in = 1'b1;
         end else if (c == quote_char) begin
            // closing quote: emit and drop the token
            has_result  = 1'b1;
            res_quoted  = 1'b1;
            in_token_in = 1'b0;
            in_quote_in = 1'b0;
            dquote_in   = 1'b0;
            esc_in      = 1'b0;
            start_in    = '0;
         end
      end else if (c > qts_pkg::CHAR_SPACE) begin
         if (!tok) begin
            in_token_in = 1'b1;
            if (c == qts_pkg::CHAR_DQUOTE || c == qts_pkg::CHAR_SQUOTE) begin
               in_quote_in = 1'b1;
               dquote_in   = (c == qts_pkg::CHAR_DQUOTE);
               start_in    = sat_inc(idx);
            end else begin
               start_in = idx;
            end
         end
      end else if (tok) begin
         // separator ends an unquoted token
         has_result  = 1'b1;
         res_line    = (c == qts_pkg::CHAR_LF) || (c == qts_pkg::CHAR_CR);
         in_token_in = 1'b0;
         in_quote_in = 1'b0;
         dquote_in   = 1'b0;
         esc_in      = 1'b0;
         start_in    = '0;
      end

      if (s1_data_ff.buffer_last) begin
         // buffer end closes any open token, unsaturated end position
         if (in_token_in) begin
            has_result = 1'b1;
            res_end    = {1'b0, idx} + 1'b1;
            res_start  = start_in;
            res_quoted = in_quote_in;
            res_line   = 1'b0;
            res_open   = in_quote_in;
         end
         in_token_in = 1'b0;
         in_quote_in = 1'b0;
         dquote_in   = 1'b0;
         esc_in      = 1'b0;
         start_in    = '0;
         pos_in      = '0;
      end else begin
         pos_in = sat_inc(idx);
      end
   end

   // Length never negative, saturated to 16 bits.
   always_comb begin
      res_len = (res_end > {1'b0, res_start}) ? res_end - {1'b0, res_start} : '0;
      rsp_data_in.token_offset = res_start;
      rsp_data_in.token_length = res_len[PW] ? '1 : res_len[PW-1:0];
      rsp_data_in.was_quoted   = res_quoted;
      rsp_data_in.ends_line    = res_line;
      rsp_data_in.unterminated = res_open;
   end

   // Handshake: a byte without a result never waits for the result register.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && (!has_result || out_free);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign s1_valid_in = (req_valid && !req_stall) || (s1_valid_ff && !s1_advance);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = s1_advance && has_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         in_token_ff  <= 1'b0;
         in_quote_ff  <= 1'b0;
         dquote_ff    <= 1'b0;
         esc_ff       <= 1'b0;
         start_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_advance) begin
            pos_ff      <= pos_in;
            in_token_ff <= in_token_in;
            in_quote_ff <= in_quote_in;
            dquote_ff   <= dquote_in;
            esc_ff      <= esc_in;
            start_ff    <= start_in;
         end
      end
   end

   // Payload registers: load on accept, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_data_ff <= req_data;
      end
      if (out_free && s1_advance && has_result) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/qts_checker.sv =====
// Port-level checks of the quoted token splitter, bound to its top level.
// Depends on qts_pkg and on the macros in assert_macros.svh.
`include "assert_macros.svh"

module qts_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input qts_pkg::req_payload_type req_data,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input qts_pkg::rsp_payload_type rsp_data
);

   logic req_beat;
   assign req_beat = req_valid && !req_stall;

   // no result survives reset
   `QTS_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "result valid after reset")

   // a stalled result holds
   `QTS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled result changed")

   // a fresh result follows an accepted byte
   `QTS_ASSERT(a_rsp_latency, clock, reset, $rose(rsp_valid) |-> $past(req_beat, 2), "result without a byte two cycles before")

   // an open quoted token is only reported for the final byte of a buffer
   `QTS_ASSERT(a_open_at_end, clock, reset, $rose(rsp_valid) && rsp_data.unterminated |-> $past(req_data.buffer_last, 2), "unterminated token not at buffer end")

   // flag combinations: open implies quoted, line end implies unquoted
   `QTS_ASSERT(a_flags, clock, reset, rsp_valid |-> !(rsp_data.unterminated && !rsp_data.was_quoted) && !(rsp_data.ends_line && rsp_data.was_quoted), "inconsistent token flags")

endmodule

bind quoted_token_splitter qts_checker u_qts_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
